// ----- hdl/harsh_event_driving_score_macros.svh -----
// ---------------------------------------------------------------------------
// Harsh event driving score assertion macros
// Assertion helpers for the RTL; they compile to nothing under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef HARSH_EVENT_DRIVING_SCORE_MACROS_SVH
`define HARSH_EVENT_DRIVING_SCORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define HEDS_ASSERT_IMPLY(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("heds: same-cycle check failed");
// Next-cycle implication.
`define HEDS_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("heds: next-cycle check failed");
`else
`define HEDS_ASSERT_IMPLY(name, pre, post)
`define HEDS_ASSERT_NEXT(name, pre, post)
`endif

`endif

// ----- hdl/heds_pkg.sv -----
// ---------------------------------------------------------------------------
// Harsh event driving score package
// Field widths, register indexes, controller states and command/status types.
// ---------------------------------------------------------------------------
package heds_pkg;

  localparam int SPEED_W    = 16;
  localparam int TIME_W     = 32;
  localparam int ACCEL_W    = 16;
  localparam int SCORE_W    = 8;
  localparam int FLAGS_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // |speed delta| * 1000 stays below 2^26
  localparam int MAG_W   = 26;
  localparam int MULT_W  = 10;
  localparam logic [MULT_W-1:0] MS_PER_S = 10'd1000;

  localparam logic [MAG_W-1:0] ACCEL_POS_LIMIT = 26'd32767;
  localparam logic [MAG_W-1:0] ACCEL_NEG_LIMIT = 26'd32768;
  localparam logic [ACCEL_W-1:0] ACCEL_MAX = 16'h7fff;
  localparam logic [ACCEL_W-1:0] ACCEL_MIN = 16'h8000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_PENALTY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_PENALTY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_STEP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_CEILING   = 3'd5;

  // register reset values
  localparam logic signed [ACCEL_W-1:0] BRAKE_THRESHOLD_RST = -16'sd3072;
  localparam logic signed [ACCEL_W-1:0] ACCEL_THRESHOLD_RST = 16'sd2560;
  localparam logic [SCORE_W-1:0] BRAKE_PENALTY_RST = 8'd4;
  localparam logic [SCORE_W-1:0] ACCEL_PENALTY_RST = 8'd3;
  localparam logic [SCORE_W-1:0] RECOVERY_STEP_RST = 8'd1;
  localparam logic [SCORE_W-1:0] SCORE_CEILING_RST = 8'd100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_SAT,
    ST_DONE
  } heds_state_t;

  typedef struct packed {
    logic load;       // capture the input word
    logic calc;       // form delta and elapsed, update last sample
    logic div_start;  // launch the divider
    logic sat;        // saturate quotient, compare thresholds
    logic finish;     // update score, load the output register
  } heds_cmd_t;

  typedef struct packed {
    logic short_int;  // elapsed time of 0 or 1 ms
    logic div_done;   // quotient ready
    logic out_free;   // output register can take a word
  } heds_status_t;

endpackage

// ----- hdl/heds_ctrl.sv -----
// ---------------------------------------------------------------------------
// Harsh event driving score controller
// Sequences one sample through capture, divide (skipped for a short interval), saturate and score update.
// ---------------------------------------------------------------------------
module heds_ctrl import heds_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  heds_status_t status,
  output heds_cmd_t    cmd
);

  heds_state_t state;
  heds_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc = 1'b1;
        if (status.short_int) begin
          state_next = ST_SAT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_next = ST_SAT;
        end
      end
      ST_SAT: begin
        cmd.sat    = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // hold until the previous result is taken
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/heds_div.sv -----
// ---------------------------------------------------------------------------
// Harsh event driving score divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`include "harsh_event_driving_score_macros.svh"

module heds_div import heds_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [MAG_W-1:0]     dividend,
  input  logic [TIME_BITS-1:0] divisor,
  output logic [MAG_W-1:0]     quotient,
  output logic                 done
);

  localparam int CNT_W = $clog2(MAG_W);

  logic [MAG_W-1:0]     quo;
  logic [TIME_BITS-1:0] rem;
  logic [TIME_BITS-1:0] dvs;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic [TIME_BITS:0]   trial;
  logic                 fits;

  assign trial = {rem, quo[MAG_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MAG_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // hold the divisor: the caller moves on to the next sample's state
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= TIME_BITS'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[TIME_BITS-1:0];
      end
      quo <= {quo[MAG_W-2:0], fits};
    end
  end

  assign quotient = quo;

  `HEDS_ASSERT_IMPLY(a_start_idle, start, !busy)
  `HEDS_ASSERT_IMPLY(a_done_idle, done, !busy)
  `HEDS_ASSERT_NEXT(a_last_step, busy && (cnt == '0), done && !busy)

endmodule

// ----- hdl/heds_datapath.sv -----
// ---------------------------------------------------------------------------
// Harsh event driving score datapath
// Sample state, configuration registers, divider, scoring and output register.
// ---------------------------------------------------------------------------
module heds_datapath import heds_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  heds_cmd_t             cmd,
  output heds_status_t          status,
  input  logic [SPEED_W-1:0]    speed,
  input  logic [TIME_W-1:0]     sample_time_ms,
  input  logic                  gps_fix,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ACCEL_W-1:0]    accel,
  output logic [SCORE_W-1:0]    score,
  output logic [FLAGS_W-1:0]    event_flags
);

  // configuration
  logic signed [ACCEL_W-1:0] brake_threshold;
  logic signed [ACCEL_W-1:0] accel_threshold;
  logic [SCORE_W-1:0]        brake_penalty;
  logic [SCORE_W-1:0]        accel_penalty;
  logic [SCORE_W-1:0]        recovery_step;
  logic [SCORE_W-1:0]        score_ceiling;

  // sample state
  logic [SPEED_W-1:0]   last_speed;
  logic [TIME_BITS-1:0] last_time;
  logic [SCORE_W-1:0]   running_score;

  // captured word
  logic [SPEED_W-1:0]   spd;
  logic [TIME_BITS-1:0] now;
  logic                 gps;

  logic neg;
  logic short_int;
  logic signed [ACCEL_W-1:0] accel_sat;
  logic hb;
  logic ha;

  logic [TIME_BITS-1:0] elapsed;
  logic [SPEED_W-1:0]   abs_delta;
  logic [MAG_W-1:0]     mag;
  logic [MAG_W-1:0]     quotient;
  logic                 div_done;
  logic [ACCEL_W-1:0]   accel_calc;
  logic signed [SCORE_W+1:0] sc_raw;
  logic [SCORE_W-1:0]   sc_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      brake_threshold <= BRAKE_THRESHOLD_RST;
      accel_threshold <= ACCEL_THRESHOLD_RST;
      brake_penalty   <= BRAKE_PENALTY_RST;
      accel_penalty   <= ACCEL_PENALTY_RST;
      recovery_step   <= RECOVERY_STEP_RST;
      score_ceiling   <= SCORE_CEILING_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BRAKE_THRESHOLD: brake_threshold <= cfg_data;
        REG_ACCEL_THRESHOLD: accel_threshold <= cfg_data;
        REG_BRAKE_PENALTY:   brake_penalty   <= cfg_data[SCORE_W-1:0];
        REG_ACCEL_PENALTY:   accel_penalty   <= cfg_data[SCORE_W-1:0];
        REG_RECOVERY_STEP:   recovery_step   <= cfg_data[SCORE_W-1:0];
        REG_SCORE_CEILING:   score_ceiling   <= cfg_data[SCORE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      spd <= speed;
      now <= sample_time_ms[TIME_BITS-1:0];
      gps <= gps_fix;
    end
  end

  assign elapsed   = now - last_time;
  assign abs_delta = (spd >= last_speed) ? spd - last_speed : last_speed - spd;
  assign mag       = MAG_W'(abs_delta) * MAG_W'(MS_PER_S);

  heds_div #(
    .TIME_BITS (TIME_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (mag),
    .divisor  (elapsed),
    .quotient (quotient),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      last_speed    <= '0;
      last_time     <= '0;
      running_score <= SCORE_CEILING_RST;
    end else begin
      if (cmd.calc) begin
        last_speed <= spd;
        last_time  <= now;
      end
      if (cmd.finish) begin
        running_score <= sc_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      neg       <= spd < last_speed;
      short_int <= elapsed <= TIME_BITS'(1);
    end
  end

  // saturate the magnitude, then restore the sign; a short interval gives zero
  always_comb begin
    if (neg) begin
      accel_calc = (quotient >= ACCEL_NEG_LIMIT) ? ACCEL_MIN
                 : ACCEL_W'(-quotient[ACCEL_W-1:0]);
    end else begin
      accel_calc = (quotient > ACCEL_POS_LIMIT) ? ACCEL_MAX : quotient[ACCEL_W-1:0];
    end
    if (short_int) begin
      accel_calc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sat) begin
      accel_sat <= accel_calc;
      hb <= !short_int && (signed'(accel_calc) < brake_threshold);
      ha <= !short_int && (signed'(accel_calc) > accel_threshold);
    end
  end

  always_comb begin
    if (hb) begin
      sc_raw = signed'({2'b00, running_score}) - signed'({2'b00, brake_penalty});
    end else if (ha) begin
      sc_raw = signed'({2'b00, running_score}) - signed'({2'b00, accel_penalty});
    end else begin
      sc_raw = signed'({2'b00, running_score}) + signed'({2'b00, recovery_step});
    end
    if (sc_raw < 0) begin
      sc_new = '0;
    end else if (sc_raw > signed'({2'b00, score_ceiling})) begin
      sc_new = score_ceiling;
    end else begin
      sc_new = sc_raw[SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      accel       <= accel_sat;
      score       <= sc_new;
      event_flags <= {!gps, ha, hb};
    end
  end

  always_comb begin
    status.short_int = elapsed <= TIME_BITS'(1);
    status.div_done  = div_done;
    status.out_free  = !out_valid || out_ready;
  end

endmodule

// ----- hdl/harsh_event_driving_score.sv -----
// Flow: an accepted word passes through capture, the 26-step restoring divider,
//   saturation and the score update; the divider is skipped for 0 or 1 ms.
// Samples: the controller works on one sample at a time and takes no new word
//   until the last one is done, and a full output register holds it in place.
// Reset: synchronous rst restores register defaults, zero last sample, score 100.
// ---------------------------------------------------------------------------
// Harsh event driving score
// Turns timed speed samples into acceleration, harsh event flags and a
// running driving score with configurable thresholds and penalties.
// ---------------------------------------------------------------------------
module harsh_event_driving_score import heds_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // sample channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SPEED_W-1:0]    speed,
  input  logic [TIME_W-1:0]     sample_time_ms,
  input  logic                  gps_fix,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ACCEL_W-1:0]    accel,
  output logic [SCORE_W-1:0]    score,
  output logic [FLAGS_W-1:0]    event_flags,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  heds_cmd_t    cmd;
  heds_status_t status;

  // Every register write is accepted when offered, so the write channel never stalls.
  assign cfg_ready = 1'b1;

  // Controller: capture a word, compute delta and elapsed time, run the divider
  // unless the interval is too short, saturate, then update the score and hand
  // the result word to the output register once that register is free.
  heds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: the previous sample, the running score, the registers, the
  // divider and the output register that holds a word until the sink takes it.
  heds_datapath #(
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .speed          (speed),
    .sample_time_ms (sample_time_ms),
    .gps_fix        (gps_fix),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .accel          (accel),
    .score          (score),
    .event_flags    (event_flags)
  );

endmodule

// ----- test/heds_score_checker.sv -----
// ---------------------------------------------------------------------------
// Harsh event driving score checker
// Watches the sample, result and configuration channels, predicts every
// result word from its own copy of the score state and compares in order.
// ---------------------------------------------------------------------------
module heds_score_checker import heds_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [SPEED_W-1:0]    speed,
  input  logic [TIME_W-1:0]     sample_time_ms,
  input  logic                  gps_fix,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [ACCEL_W-1:0]    accel,
  input  logic [SCORE_W-1:0]    score,
  input  logic [FLAGS_W-1:0]    event_flags,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic [ACCEL_W-1:0] accel;
    logic [SCORE_W-1:0] score;
    logic [FLAGS_W-1:0] flags;
  } score_word_t;

  shortint            brake_thr     = BRAKE_THRESHOLD_RST;
  shortint            accel_thr     = ACCEL_THRESHOLD_RST;
  logic [SCORE_W-1:0] brake_pen     = BRAKE_PENALTY_RST;
  logic [SCORE_W-1:0] accel_pen     = ACCEL_PENALTY_RST;
  logic [SCORE_W-1:0] recover_step  = RECOVERY_STEP_RST;
  logic [SCORE_W-1:0] ceiling       = SCORE_CEILING_RST;
  logic [SPEED_W-1:0] last_speed    = '0;
  logic [TIME_W-1:0]  last_time     = '0;
  logic [SCORE_W-1:0] running_score = SCORE_CEILING_RST;

  score_word_t awaited_words[$];
  int          faults = 0;

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_BRAKE_THRESHOLD: brake_thr    = $signed(data);
      REG_ACCEL_THRESHOLD: accel_thr    = $signed(data);
      REG_BRAKE_PENALTY:   brake_pen    = data[SCORE_W-1:0];
      REG_ACCEL_PENALTY:   accel_pen    = data[SCORE_W-1:0];
      REG_RECOVERY_STEP:   recover_step = data[SCORE_W-1:0];
      REG_SCORE_CEILING:   ceiling      = data[SCORE_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance the score state by one sample and return its result word.
  function automatic score_word_t score_sample(logic [SPEED_W-1:0] spd,
                                               logic [TIME_W-1:0] now, logic gps);
    logic [TIME_W-1:0] elapsed;
    longint            num;
    longint            quo;
    int                acc;
    int                sc;
    logic              hb;
    logic              ha;
    score_word_t       w;
    elapsed = now - last_time;
    acc = 0;
    hb  = 1'b0;
    ha  = 1'b0;
    if (elapsed > 32'd1) begin
      num = (longint'(spd) - longint'(last_speed)) * 1000;
      quo = num / longint'(elapsed);
      if (quo > 32767) quo = 32767;
      if (quo < -32768) quo = -32768;
      acc = int'(quo);
      hb  = acc < int'(brake_thr);
      ha  = acc > int'(accel_thr);
    end
    sc = int'(running_score);
    if (hb) sc -= int'(brake_pen);
    else if (ha) sc -= int'(accel_pen);
    else sc += int'(recover_step);
    if (sc < 0) sc = 0;
    if (sc > int'(ceiling)) sc = int'(ceiling);
    running_score = 8'(sc);
    last_speed    = spd;
    last_time     = now;
    w.accel = 16'(acc);
    w.score = running_score;
    w.flags = {~gps, ha, hb};
    return w;
  endfunction

  always @(posedge clk) begin
    score_word_t want;
    if (rst) begin
      brake_thr     = BRAKE_THRESHOLD_RST;
      accel_thr     = ACCEL_THRESHOLD_RST;
      brake_pen     = BRAKE_PENALTY_RST;
      accel_pen     = ACCEL_PENALTY_RST;
      recover_step  = RECOVERY_STEP_RST;
      ceiling       = SCORE_CEILING_RST;
      last_speed    = '0;
      last_time     = '0;
      running_score = SCORE_CEILING_RST;
      awaited_words.delete();
    end else begin
      // compare the outgoing word first: it always belongs to an older sample
      if (out_valid && out_ready) begin
        if (awaited_words.size() == 0) begin
          if (faults < 10)
            $display("checker: unexpected result word accel=%h score=%0d flags=%b",
                     accel, score, event_flags);
          faults++;
        end else begin
          want = awaited_words.pop_front();
          if (want.accel !== accel || want.score !== score || want.flags !== event_flags) begin
            if (faults < 10) begin
              $write("checker: mismatch, expected accel=%h score=%0d flags=%b,",
                     want.accel, want.score, want.flags);
              $display(" got accel=%h score=%0d flags=%b", accel, score, event_flags);
            end
            faults++;
          end
        end
      end
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready)
        awaited_words.push_back(score_sample(speed, sample_time_ms, gps_fix));
    end
    fail_count <= faults;
    pending    <= awaited_words.size();
  end

endmodule

// ----- test/harsh_event_driving_score_test.sv -----
// ---------------------------------------------------------------------------
// Harsh event driving score testbench
// Drives directed and random speed samples and register writes into the
// block under several idle patterns; a checker beside it predicts and
// compares every result word, and this top gives the verdict.
// ---------------------------------------------------------------------------
module harsh_event_driving_score_test;
  import heds_pkg::*;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  // indexes past the register file, written to confirm they are ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int SEGMENTS     = 8;
  localparam int SEG_ITEMS    = 220;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_GAP      = 16;
  localparam int DRAIN_CYCLES = 40;
  localparam int RUN_LIMIT    = 8_000_000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SPEED_W-1:0]    speed = '0;
  logic [TIME_W-1:0]     sample_time_ms = '0;
  logic                  gps_fix = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ACCEL_W-1:0]    accel;
  logic [SCORE_W-1:0]    score;
  logic [FLAGS_W-1:0]    event_flags;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;

  // idle percentages, written by the stimulus only
  int send_pct = 0;
  int recv_pct = 0;
  // bump to ask the sink process for one long hold-off
  int hold_seq = 0;

  // running sample generator state
  int                cur_speed = 0;
  logic [TIME_W-1:0] t_now = '0;

  harsh_event_driving_score dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .speed          (speed),
    .sample_time_ms (sample_time_ms),
    .gps_fix        (gps_fix),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .accel          (accel),
    .score          (score),
    .event_flags    (event_flags),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  heds_score_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .speed          (speed),
    .sample_time_ms (sample_time_ms),
    .gps_fix        (gps_fix),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .accel          (accel),
    .score          (score),
    .event_flags    (event_flags),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stop a hung run; this limit sits far above the slowest correct run.
  initial begin
    #RUN_LIMIT;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Sink side: drop out_ready at random per cycle, or for one long stretch
  // on request. The stretch is counted here so the sender keeps going and
  // the block backs up into its input.
  initial begin
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_pct);
      end
    end
  end

  function automatic void set_idle(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin send_pct = 0;  recv_pct = 0;  end
      IDLE_SEND: begin send_pct = 60; recv_pct = 0;  end
      IDLE_RECV: begin send_pct = 0;  recv_pct = 60; end
      IDLE_BOTH: begin send_pct = 14; recv_pct = 14; end
      default:   begin send_pct = 0;  recv_pct = 0;  end
    endcase
  endfunction

  // Offer one sample word after an optional idle gap, hold it until taken.
  task automatic put_sample(logic [SPEED_W-1:0] s, logic [TIME_W-1:0] t, logic g);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    speed          <= s;
    sample_time_ms <= t;
    gps_fix        <= g;
    do @(posedge clk); while (!in_ready);
  endtask

  // Release the sample channel and hold until every result word is back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Write one register; call only while the block is drained.
  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Eight-bit registers get random junk in the upper half of the data word.
  function automatic logic [CFG_DATA_W-1:0] byte_word(logic [7:0] v);
    return {8'($urandom), v};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_threshold(logic neg);
    if ($urandom_range(3) == 0) return 16'($urandom);
    if (neg) return 16'(-int'($urandom_range(500, 6000)));
    return 16'($urandom_range(500, 6000));
  endfunction

  // Load a full register set for one random segment.
  task automatic pick_settings(int seg);
    drain_results();
    case (seg)
      0: begin
        set_reg(REG_BRAKE_THRESHOLD, BRAKE_THRESHOLD_RST);
        set_reg(REG_ACCEL_THRESHOLD, ACCEL_THRESHOLD_RST);
        set_reg(REG_BRAKE_PENALTY, byte_word(BRAKE_PENALTY_RST));
        set_reg(REG_ACCEL_PENALTY, byte_word(ACCEL_PENALTY_RST));
        set_reg(REG_RECOVERY_STEP, byte_word(RECOVERY_STEP_RST));
        set_reg(REG_SCORE_CEILING, byte_word(SCORE_CEILING_RST));
      end
      1: begin
        // widest thresholds: nothing is ever harsh
        set_reg(REG_BRAKE_THRESHOLD, 16'h8000);
        set_reg(REG_ACCEL_THRESHOLD, 16'h7fff);
        set_reg(REG_BRAKE_PENALTY, byte_word(8'd0));
        set_reg(REG_ACCEL_PENALTY, byte_word(8'd0));
        set_reg(REG_RECOVERY_STEP, byte_word(8'd0));
        set_reg(REG_SCORE_CEILING, byte_word(8'd255));
      end
      2: begin
        // inverted thresholds: both flags on every long interval not at a limit
        set_reg(REG_BRAKE_THRESHOLD, 16'h7fff);
        set_reg(REG_ACCEL_THRESHOLD, 16'h8000);
        set_reg(REG_BRAKE_PENALTY, byte_word(8'd255));
        set_reg(REG_ACCEL_PENALTY, byte_word(8'd255));
        set_reg(REG_RECOVERY_STEP, byte_word(8'd255));
        set_reg(REG_SCORE_CEILING, byte_word(8'd0));
      end
      default: begin
        set_reg(REG_BRAKE_THRESHOLD, rand_threshold(1'b1));
        set_reg(REG_ACCEL_THRESHOLD, rand_threshold(1'b0));
        set_reg(REG_BRAKE_PENALTY, byte_word(8'($urandom_range(0, 20))));
        set_reg(REG_ACCEL_PENALTY, byte_word(8'($urandom_range(0, 20))));
        set_reg(REG_RECOVERY_STEP, byte_word(8'($urandom_range(0, 10))));
        set_reg(REG_SCORE_CEILING, byte_word(8'($urandom_range(0, 255))));
      end
    endcase
  endtask

  // Mostly plausible driving: small time steps and speed changes that land
  // near the thresholds; the rest are short intervals, wild jumps in time,
  // full-range speeds and timestamps that run backward.
  task automatic random_sample();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) begin
      t_now     = t_now + $urandom_range(2, 250);
      cur_speed = cur_speed + int'($urandom_range(0, 4000)) - 2000;
    end else if (sel < 80) begin
      t_now     = t_now + $urandom_range(0, 1);
      cur_speed = cur_speed + int'($urandom_range(0, 400)) - 200;
    end else if (sel < 88) begin
      t_now     = $urandom;
    end else if (sel < 94) begin
      t_now     = t_now + $urandom_range(2, 40);
      cur_speed = int'($urandom_range(0, 65535));
    end else begin
      t_now     = t_now - $urandom_range(1, 1000);
    end
    if (cur_speed < 0) cur_speed = 0;
    if (cur_speed > 65535) cur_speed = 65535;
    put_sample(16'(cur_speed), t_now, ($urandom_range(99) < 85));
  endtask

  initial begin
    set_idle(IDLE_NONE);
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // --- directed part, reset register values ---
    // first sample after reset sees a zero last sample: short interval
    put_sample(16'h0000, 32'd0, 1'b1);
    // full-scale jumps saturate both ways
    put_sample(16'hffff, 32'd2, 1'b1);
    put_sample(16'h0000, 32'd4, 1'b0);
    // one and zero ms intervals
    put_sample(16'd1000, 32'd5, 1'b1);
    put_sample(16'd1000, 32'd5, 1'b1);
    // timestamp going back reads as a long interval
    put_sample(16'd5000, 32'd0, 1'b1);
    // wrap across the top of the counter
    put_sample(16'd5000, 32'hffff_ffff, 1'b1);
    put_sample(16'd2000, 32'h0000_0001, 1'b1);
    put_sample(16'd2500, 32'd101, 1'b1);
    put_sample(16'd2500, 32'd201, 1'b1);
    put_sample(16'haaaa, 32'h5555_5555, 1'b0);
    put_sample(16'h5555, 32'haaaa_aaaa, 1'b1);

    // penalty larger than score floors it at zero
    drain_results();
    set_reg(REG_BRAKE_PENALTY, 16'ha5ff);
    put_sample(16'h0000, 32'haaaa_aab4, 1'b1);
    // climb to the top of the range
    drain_results();
    set_reg(REG_RECOVERY_STEP, 16'h5aff);
    set_reg(REG_SCORE_CEILING, 16'hc3ff);
    put_sample(16'h0000, 32'haaaa_ab00, 1'b1);
    // lower the ceiling under the running score
    drain_results();
    set_reg(REG_SCORE_CEILING, byte_word(8'd10));
    put_sample(16'h0000, 32'haaaa_ac00, 1'b1);
    // both thresholds crossed: brake penalty wins
    drain_results();
    set_reg(REG_BRAKE_THRESHOLD, 16'h7fff);
    set_reg(REG_ACCEL_THRESHOLD, 16'h8000);
    set_reg(REG_SCORE_CEILING, byte_word(8'd255));
    put_sample(16'd300, 32'haaaa_ad00, 1'b0);
    // writes past the register file change nothing
    drain_results();
    set_reg(REG_SPARE_LO, 16'hffff);
    set_reg(REG_SPARE_HI, 16'h0000);
    put_sample(16'd300, 32'haaaa_ae00, 1'b1);
    // zero ceiling pins the score
    drain_results();
    set_reg(REG_SCORE_CEILING, byte_word(8'd0));
    put_sample(16'd9000, 32'haaaa_af00, 1'b1);

    cur_speed = 9000;
    t_now     = 32'haaaa_af00;

    // --- random part: one register set and one idle pattern per segment ---
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      pick_settings(seg);
      set_idle(idle_mode_t'(seg % 4));
      for (int n = 0; n < SEG_ITEMS; n++) begin
        if (seg == 0 && n == 40) hold_seq++;
        if (seg == 0 && n == 120) drain_results();
        random_sample();
      end
    end

    // release the channel, let the last words out, then a little slack
    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/heds_pkg.sv
hdl/heds_ctrl.sv
hdl/heds_div.sv
hdl/heds_datapath.sv
hdl/harsh_event_driving_score.sv
test/heds_score_checker.sv
test/harsh_event_driving_score_test.sv
